@@ rtl/core/qfun_pkg.sv @@
// Shared constants, command/status types and the triple table for the quad face normal unit.
package qfun_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int THR_BITS       = 32;
    localparam logic [THR_BITS-1:0] THR_RESET = 32'd43;

    localparam int NORM_BITS = 30;                          // normalized magnitude width
    localparam int FRAC_OUT  = 16;
    localparam int OUT_BITS  = 18;
    localparam int Q_BITS    = FRAC_OUT + 1;                // quotient never exceeds 65536
    localparam int LEN_BITS  = NORM_BITS + 1;
    localparam int ACC_BITS  = 2 * NORM_BITS + 2;
    localparam int NUM_BITS  = NORM_BITS + FRAC_OUT + 1;

    localparam int CNT_BITS = 5;
    localparam logic [CNT_BITS-1:0] CROSS_LAST = 5'd6;
    localparam logic [CNT_BITS-1:0] SQ_LAST    = 5'd3;
    localparam logic [CNT_BITS-1:0] ROOT_LAST  = 5'd31;
    localparam logic [CNT_BITS-1:0] DIV_LAST   = 5'd18;
    localparam logic [1:0]          LAST_TRIPLE = 2'd3;
    localparam logic [1:0]          LAST_COMP   = 2'd2;

    typedef logic [3:0] op_t;
    localparam op_t OP_IDLE      = 4'd0;
    localparam op_t OP_LOAD      = 4'd1;
    localparam op_t OP_CROSS     = 4'd2;
    localparam op_t OP_NLOAD     = 4'd3;
    localparam op_t OP_NORM      = 4'd4;
    localparam op_t OP_SQ        = 4'd5;
    localparam op_t OP_SQRT_INIT = 4'd6;
    localparam op_t OP_SQRT      = 4'd7;
    localparam op_t OP_DIV_INIT  = 4'd8;
    localparam op_t OP_DIV       = 4'd9;
    localparam op_t OP_DIV_STORE = 4'd10;
    localparam op_t OP_DEGEN     = 4'd11;

    typedef struct packed {
        op_t                 op;
        logic [CNT_BITS-1:0] cnt;
        logic [1:0]          triple;
        logic [1:0]          comp;
    } cmd_t;

    typedef struct packed {
        logic qualify;
        logic norm_done;
    } status_t;

    // vertex indices (a, b, c) of each triple
    localparam logic [1:0] TRI_VTX [4][3] = '{
        '{2'd0, 2'd1, 2'd2},
        '{2'd0, 2'd1, 2'd3},
        '{2'd0, 2'd2, 2'd3},
        '{2'd1, 2'd2, 2'd3}
    };

endpackage

@@ rtl/core/qfun_if.sv @@
// Valid/ready channel interfaces for vertex input and normal output.
interface qfun_vtx_if #(
    parameter int COORD_BITS = qfun_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex0_x;
    logic signed [COORD_BITS-1:0] vertex0_y;
    logic signed [COORD_BITS-1:0] vertex0_z;
    logic signed [COORD_BITS-1:0] vertex1_x;
    logic signed [COORD_BITS-1:0] vertex1_y;
    logic signed [COORD_BITS-1:0] vertex1_z;
    logic signed [COORD_BITS-1:0] vertex2_x;
    logic signed [COORD_BITS-1:0] vertex2_y;
    logic signed [COORD_BITS-1:0] vertex2_z;
    logic signed [COORD_BITS-1:0] vertex3_x;
    logic signed [COORD_BITS-1:0] vertex3_y;
    logic signed [COORD_BITS-1:0] vertex3_z;

    modport source (
        output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z, vertex3_x, vertex3_y, vertex3_z,
        input  ready
    );
    modport sink (
        input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z, vertex3_x, vertex3_y, vertex3_z,
        output ready
    );
endinterface

interface qfun_nrm_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qfun_pkg::OUT_BITS-1:0] normal_x;
    logic signed [qfun_pkg::OUT_BITS-1:0] normal_y;
    logic signed [qfun_pkg::OUT_BITS-1:0] normal_z;
    logic [1:0]                           triple_used;
    logic                                 all_degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, triple_used, all_degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, triple_used, all_degenerate,
        output ready
    );
endinterface

@@ rtl/core/qfun_ctrl.sv @@
// Sequencer for the quad face normal unit: steps the datapath through each phase.
module qfun_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_free,
    output logic              commit,
    input  qfun_pkg::status_t status,
    output qfun_pkg::cmd_t    cmd
);
    import qfun_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CROSS = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_NORM  = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_ROOT  = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]          state_reg,  state_next;
    logic [CNT_BITS-1:0] cnt_reg,    cnt_next;
    logic [1:0]          triple_reg, triple_next;
    logic [1:0]          comp_reg,   comp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            triple_reg <= '0;
            comp_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            triple_reg <= triple_next;
            comp_reg   <= comp_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        triple_next = triple_reg;
        comp_next   = comp_reg;
        cmd.op      = OP_IDLE;
        cmd.cnt     = cnt_reg;
        cmd.triple  = triple_reg;
        cmd.comp    = comp_reg;
        in_ready    = 1'b0;
        commit      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op      = OP_LOAD;
                    triple_next = '0;
                    cnt_next    = '0;
                    state_next  = S_CROSS;
                end
            end
            S_CROSS:
            begin
                cmd.op = OP_CROSS;
                if (cnt_reg == CROSS_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_CHECK:
            begin
                priority if (status.qualify)
                begin
                    cmd.op     = OP_NLOAD;
                    state_next = S_NORM;
                end
                else if (triple_reg == LAST_TRIPLE)
                begin
                    cmd.op     = OP_DEGEN;
                    state_next = S_FIN;
                end
                else
                begin
                    triple_next = triple_reg + 2'd1;
                    state_next  = S_CROSS;
                end
            end
            S_NORM:
            begin
                if (status.norm_done)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    cmd.op = OP_NORM;
                end
            end
            S_SQ:
            begin
                cmd.op = OP_SQ;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_ROOT:
            begin
                cmd.op = (cnt_reg == '0) ? OP_SQRT_INIT : OP_SQRT;
                if (cnt_reg == ROOT_LAST)
                begin
                    cnt_next   = '0;
                    comp_next  = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_DIV:
            begin
                priority if (cnt_reg == '0)
                    cmd.op = OP_DIV_INIT;
                else if (cnt_reg == DIV_LAST)
                    cmd.op = OP_DIV_STORE;
                else
                    cmd.op = OP_DIV;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = '0;
                    if (comp_reg == LAST_COMP)
                        state_next = S_FIN;
                    else
                        comp_next = comp_reg + 2'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> state_reg == S_IDLE)
        else $error("commit did not return to idle");
    a_all_degen_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && !status.qualify && triple_reg == LAST_TRIPLE)
            |=> state_reg == S_FIN)
        else $error("last degenerate triple did not finish");
    a_cross_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CROSS |-> cnt_reg <= CROSS_LAST)
        else $error("cross product step out of range");
`endif

endmodule

@@ rtl/core/qfun_dpath.sv @@
// Datapath: cross products, normalizing shifter, square root and divider.
module qfun_dpath #(
    parameter int COORD_BITS = qfun_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  qfun_pkg::cmd_t                       cmd,
    input  logic [11:0][COORD_BITS-1:0]          vtx_in,
    input  logic [qfun_pkg::THR_BITS-1:0]        thr,
    output qfun_pkg::status_t                    status,
    output logic signed [qfun_pkg::OUT_BITS-1:0] res_x,
    output logic signed [qfun_pkg::OUT_BITS-1:0] res_y,
    output logic signed [qfun_pkg::OUT_BITS-1:0] res_z,
    output logic [1:0]                           res_triple,
    output logic                                 res_degen
);
    import qfun_pkg::*;

    localparam int DW = COORD_BITS + 1;             // vertex difference
    localparam int PW = 2 * DW;                     // product and cross component
    localparam int RW = (PW > NORM_BITS + 1) ? PW : NORM_BITS + 1;
    localparam int CW = (PW > THR_BITS) ? PW : THR_BITS;

    logic signed [COORD_BITS-1:0] v_reg [4][3];
    logic signed [PW-1:0]         n_reg [3];
    logic signed [PW-1:0]         prod_reg;
    logic [RW-1:0]                r_reg [3];
    logic [2*NORM_BITS-1:0]       sqp_reg;
    logic [ACC_BITS-1:0]          acc_reg;
    logic [ACC_BITS-1:0]          x_reg, root_reg, bit_reg;
    logic [LEN_BITS-1:0]          rem_reg;
    logic [Q_BITS-1:0]            qn_reg;
    logic signed [OUT_BITS-1:0]   resn_reg [3];
    logic [1:0]                   triple_reg;
    logic                         degen_reg;

    logic [1:0]           pa, pb, pc;
    logic signed [DW-1:0] d1 [3];
    logic signed [DW-1:0] d2 [3];
    logic signed [DW-1:0] op_a, op_b;
    logic signed [PW-1:0] prod;
    logic [2:0]           jstep;
    logic [1:0]           jcomp;
    logic [PW-1:0]        mag [3];
    logic                 big, nz;
    logic [RW-1:0]        ormag;
    logic [1:0]           sq_idx;
    logic [ACC_BITS-1:0]  root_try;
    logic [LEN_BITS-1:0]  len;
    logic [NUM_BITS-1:0]  numer;
    logic [LEN_BITS:0]    rem2;
    logic                 q_bit;

    assign pa = TRI_VTX[cmd.triple][0];
    assign pb = TRI_VTX[cmd.triple][1];
    assign pc = TRI_VTX[cmd.triple][2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d1[k] = DW'(v_reg[pa][k]) - DW'(v_reg[pb][k]);
            d2[k] = DW'(v_reg[pa][k]) - DW'(v_reg[pc][k]);
        end
    end

    // n = (d1 x d2), two products per component
    always_comb
    begin
        unique case (cmd.cnt[2:0])
            3'd0:    begin op_a = d1[1]; op_b = d2[2]; end
            3'd1:    begin op_a = d2[1]; op_b = d1[2]; end
            3'd2:    begin op_a = d2[0]; op_b = d1[2]; end
            3'd3:    begin op_a = d1[0]; op_b = d2[2]; end
            3'd4:    begin op_a = d1[0]; op_b = d2[1]; end
            3'd5:    begin op_a = d2[0]; op_b = d1[1]; end
            default: begin op_a = '0;    op_b = '0;    end
        endcase
    end

    assign prod  = op_a * op_b;
    assign jstep = cmd.cnt[2:0] - 3'd1;
    assign jcomp = jstep[2:1];

    always_comb
    begin
        big = 1'b0;
        nz  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = n_reg[k][PW-1] ? PW'(-n_reg[k]) : PW'(n_reg[k]);
            if (CW'(mag[k]) >= CW'(thr))
                big = 1'b1;
            if (mag[k] != '0)
                nz = 1'b1;
        end
    end

    assign ormag            = r_reg[0] | r_reg[1] | r_reg[2];
    assign status.qualify   = big && nz;
    assign status.norm_done = (ormag[RW-1:NORM_BITS] == '0) && ormag[NORM_BITS-1];

    assign sq_idx   = cmd.cnt[1:0];
    assign root_try = root_reg + bit_reg;
    assign len      = root_reg[LEN_BITS-1:0];
    assign numer    = {1'b0, r_reg[cmd.comp][NORM_BITS-1:0], FRAC_OUT'(0)}
                      + NUM_BITS'(len[LEN_BITS-1:1]);
    assign rem2     = {rem_reg, qn_reg[Q_BITS-1]};
    assign q_bit    = rem2 >= {1'b0, len};

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                for (int i = 0; i < 4; i++)
                    for (int k = 0; k < 3; k++)
                        v_reg[i][k] <= $signed(vtx_in[i*3+k]);
            end
            OP_CROSS:
            begin
                if (cmd.cnt != CROSS_LAST)
                    prod_reg <= prod;
                if (cmd.cnt != '0)
                begin
                    if (!jstep[0])
                        n_reg[jcomp] <= prod_reg;
                    else
                        n_reg[jcomp] <= n_reg[jcomp] - prod_reg;
                end
            end
            OP_NLOAD:
            begin
                for (int k = 0; k < 3; k++)
                    r_reg[k] <= RW'(mag[k]);
                triple_reg <= cmd.triple;
                degen_reg  <= 1'b0;
            end
            OP_NORM:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (ormag[RW-1:NORM_BITS] != '0)
                        r_reg[k] <= r_reg[k] >> 1;
                    else
                        r_reg[k] <= r_reg[k] << 1;
                end
            end
            OP_SQ:
            begin
                if (cmd.cnt != SQ_LAST)
                    sqp_reg <= r_reg[sq_idx][NORM_BITS-1:0] * r_reg[sq_idx][NORM_BITS-1:0];
                if (cmd.cnt == 5'd1)
                    acc_reg <= ACC_BITS'(sqp_reg);
                else if (cmd.cnt != '0)
                    acc_reg <= acc_reg + ACC_BITS'(sqp_reg);
            end
            OP_SQRT_INIT:
            begin
                x_reg    <= acc_reg;
                root_reg <= '0;
                bit_reg  <= ACC_BITS'(1) << (ACC_BITS - 2);
            end
            OP_SQRT:
            begin
                if (x_reg >= root_try)
                begin
                    x_reg    <= x_reg - root_try;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DIV_INIT:
            begin
                rem_reg <= LEN_BITS'(numer[NUM_BITS-1:Q_BITS]);
                qn_reg  <= numer[Q_BITS-1:0];
            end
            OP_DIV:
            begin
                rem_reg <= q_bit ? LEN_BITS'(rem2 - {1'b0, len}) : LEN_BITS'(rem2);
                qn_reg  <= {qn_reg[Q_BITS-2:0], q_bit};
            end
            OP_DIV_STORE:
            begin
                if (n_reg[cmd.comp][PW-1])
                    resn_reg[cmd.comp] <= -$signed(OUT_BITS'(qn_reg));
                else
                    resn_reg[cmd.comp] <= $signed(OUT_BITS'(qn_reg));
            end
            OP_DEGEN:
            begin
                for (int k = 0; k < 3; k++)
                    resn_reg[k] <= '0;
                triple_reg <= '0;
                degen_reg  <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res_x      = resn_reg[0];
    assign res_y      = resn_reg[1];
    assign res_z      = resn_reg[2];
    assign res_triple = triple_reg;
    assign res_degen  = degen_reg;

endmodule

@@ rtl/core/quad_face_unit_normal.sv @@
// Top level of the quad face unit normal block: channels, threshold register, output register.
//
//  channel  dir  handshake     payload
//  vtx      in   valid/ready   vertex0_x .. vertex3_z, signed COORD_BITS each
//  nrm      out  valid/ready   normal_x/y/z (Q1.16), triple_used, all_degenerate
//  wr       in   wr_en only    wr_data -> degenerate_threshold
//
// One item at a time. Each tried triple runs 6 shared multiplies plus
// accumulate, then the threshold check. A qualifying triple then takes one
// bit per cycle in the normalizing shifter (up to 2*COORD_BITS-29 or 29 shifts),
// then the squares, the square root and one division per component.
// Reset clears control and sets the threshold to 43. The next item is taken as
// soon as the result sits in the output register, even while nrm is stalled.
module quad_face_unit_normal #(
    parameter int COORD_BITS = qfun_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    qfun_vtx_if.sink                      vtx,
    qfun_nrm_if.source                    nrm,
    input  logic                          wr_en,
    input  logic [qfun_pkg::THR_BITS-1:0] wr_data
);
    import qfun_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready, out_free, commit;

    logic [THR_BITS-1:0]         thr_reg;
    logic                        out_valid_reg;
    logic signed [OUT_BITS-1:0]  nx_reg, ny_reg, nz_reg;
    logic [1:0]                  trip_reg;
    logic                        degen_reg;

    logic [11:0][COORD_BITS-1:0] vtx_in;
    logic signed [OUT_BITS-1:0]  res_x, res_y, res_z;
    logic [1:0]                  res_triple;
    logic                        res_degen;

    assign vtx_in[0]  = vtx.vertex0_x;
    assign vtx_in[1]  = vtx.vertex0_y;
    assign vtx_in[2]  = vtx.vertex0_z;
    assign vtx_in[3]  = vtx.vertex1_x;
    assign vtx_in[4]  = vtx.vertex1_y;
    assign vtx_in[5]  = vtx.vertex1_z;
    assign vtx_in[6]  = vtx.vertex2_x;
    assign vtx_in[7]  = vtx.vertex2_y;
    assign vtx_in[8]  = vtx.vertex2_z;
    assign vtx_in[9]  = vtx.vertex3_x;
    assign vtx_in[10] = vtx.vertex3_y;
    assign vtx_in[11] = vtx.vertex3_z;

    // threshold register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (wr_en)
            thr_reg <= wr_data;
    end

    // output register frees the datapath for the next transfer
    assign out_free = !out_valid_reg || nrm.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (nrm.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            nx_reg    <= res_x;
            ny_reg    <= res_y;
            nz_reg    <= res_z;
            trip_reg  <= res_triple;
            degen_reg <= res_degen;
        end
    end

    assign vtx.ready          = in_ready;
    assign nrm.valid          = out_valid_reg;
    assign nrm.normal_x       = nx_reg;
    assign nrm.normal_y       = ny_reg;
    assign nrm.normal_z       = nz_reg;
    assign nrm.triple_used    = trip_reg;
    assign nrm.all_degenerate = degen_reg;

    qfun_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vtx.valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .commit   (commit),
        .status   (status),
        .cmd      (cmd)
    );

    qfun_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .clk        (clk),
        .cmd        (cmd),
        .vtx_in     (vtx_in),
        .thr        (thr_reg),
        .status     (status),
        .res_x      (res_x),
        .res_y      (res_y),
        .res_z      (res_z),
        .res_triple (res_triple),
        .res_degen  (res_degen)
    );

`ifndef ASSERT_OFF
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!out_valid_reg || nrm.ready))
        else $error("result overwrote a pending transfer");
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (nrm.valid && nrm.all_degenerate) |->
            (nrm.normal_x == '0 && nrm.normal_y == '0 && nrm.normal_z == '0
             && nrm.triple_used == '0))
        else $error("degenerate result not zero");
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        nrm.valid |->
            (nrm.normal_x >= -18'sd65536 && nrm.normal_x <= 18'sd65536 &&
             nrm.normal_y >= -18'sd65536 && nrm.normal_y <= 18'sd65536 &&
             nrm.normal_z >= -18'sd65536 && nrm.normal_z <= 18'sd65536))
        else $error("normal component out of unit range");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for quad_face_unit_normal: directed and random quads under several thresholds.
`timescale 1ns / 100ps

module testbench;
    import qfun_pkg::*;

    localparam int CB       = COORD_BITS_DEF;
    localparam int WD_LIMIT = 4000;   // cycles without any transfer before giving up

    typedef logic signed [CB-1:0] coord_t;
    typedef coord_t quad_t [4][3];

    typedef struct {
        logic signed [OUT_BITS-1:0] nx;
        logic signed [OUT_BITS-1:0] ny;
        logic signed [OUT_BITS-1:0] nz;
        logic [1:0]                 triple;
        logic                       degen;
    } normal_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [THR_BITS-1:0] wr_data;

    qfun_vtx_if #(.COORD_BITS(CB)) vtx ();
    qfun_nrm_if nrm ();

    quad_face_unit_normal #(.COORD_BITS(CB)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .vtx     (vtx),
        .nrm     (nrm),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    // testbench copy of the threshold register
    logic [THR_BITS-1:0] thr_model;
    normal_t             pending_normals[$];
    int                  fail_cnt;
    int                  burst_left;
    int                  idle_cycles;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: exact cross products, first qualifying triple, then the
    // normalize / isqrt / rounded divide sequence of the block.
    // ------------------------------------------------------------------
    function automatic normal_t face_normal(quad_t q, logic [THR_BITS-1:0] thr);
        normal_t            res;
        longint             d1[3];
        longint             d2[3];
        longint             c[3];
        longint unsigned    m[3];
        longint unsigned    r[3];
        longint unsigned    mx, s, len, rootv, bitv, quo;
        bit                 found, is_small, is_zero;
        int                 t, k, top, sh;
        res.nx = '0;
        res.ny = '0;
        res.nz = '0;
        res.triple = '0;
        res.degen = 1'b1;
        found = 0;
        for (t = 0; t < 4; t++)
        begin
            if (!found)
            begin
                for (k = 0; k < 3; k++)
                begin
                    d1[k] = longint'(q[TRI_VTX[t][0]][k]) - longint'(q[TRI_VTX[t][1]][k]);
                    d2[k] = longint'(q[TRI_VTX[t][0]][k]) - longint'(q[TRI_VTX[t][2]][k]);
                end
                c[0] = d1[1] * d2[2] - d2[1] * d1[2];
                c[1] = d2[0] * d1[2] - d1[0] * d2[2];
                c[2] = d1[0] * d2[1] - d2[0] * d1[1];
                is_small = 1;
                is_zero  = 1;
                for (k = 0; k < 3; k++)
                begin
                    m[k] = (c[k] < 0) ? longint'(-c[k]) : c[k];
                    if (m[k] >= {32'd0, thr})
                        is_small = 0;
                    if (m[k] != 0)
                        is_zero = 0;
                end
                if (!is_small && !is_zero)
                begin
                    found = 1;
                    res.triple = t[1:0];
                    res.degen = 1'b0;
                end
            end
        end
        if (!found)
            return res;

        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        top = 0;
        for (k = 0; k < 64; k++)
            if (mx[k]) top = k + 1;
        sh = top - NORM_BITS;
        s = 0;
        for (k = 0; k < 3; k++)
        begin
            r[k] = (sh >= 0) ? (m[k] >> sh) : (m[k] << (-sh));
            s += r[k] * r[k];
        end
        // bitwise integer square root
        rootv = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= rootv + bitv)
            begin
                s -= rootv + bitv;
                rootv = (rootv >> 1) + bitv;
            end
            else
                rootv >>= 1;
            bitv >>= 2;
        end
        len = rootv;
        for (k = 0; k < 3; k++)
        begin
            quo = ((r[k] << FRAC_OUT) + (len >> 1)) / len;
            if (c[k] < 0)
                quo = -quo;
            case (k)
                0: res.nx = quo[OUT_BITS-1:0];
                1: res.ny = quo[OUT_BITS-1:0];
                default: res.nz = quo[OUT_BITS-1:0];
            endcase
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every nrm transfer against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        normal_t exp_n;
        if (rst_n && nrm.valid && nrm.ready)
        begin
            if (pending_normals.size() == 0)
            begin
                $error("normal transfer with no prediction pending");
                fail_cnt++;
            end
            else
            begin
                exp_n = pending_normals.pop_front();
                check_field("normal_x", exp_n.nx, nrm.normal_x);
                check_field("normal_y", exp_n.ny, nrm.normal_y);
                check_field("normal_z", exp_n.nz, nrm.normal_z);
                check_field("triple_used", exp_n.triple, nrm.triple_used);
                check_field("all_degenerate", exp_n.degen, nrm.all_degenerate);
            end
        end
    end

    // Receiver: holds ready high or low for random stretches, sometimes
    // long runs of full throughput, sometimes long stalls.
    always @(negedge clk)
    begin
        int hold;
        if (!rst_n)
        begin
            nrm.ready = 1'b0;
            hold = 0;
        end
        else if (hold == 0)
        begin
            nrm.ready = ($urandom_range(0, 2) != 0);
            hold = nrm.ready ? $urandom_range(1, 300) : $urandom_range(1, 60);
        end
        else
            hold--;
    end

    // Watchdog: any transfer on either channel rearms it.
    always @(posedge clk)
    begin
        if ((vtx.valid && vtx.ready) || (nrm.valid && nrm.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("** quad_face_unit_normal: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: one quad per call, bursts with random gaps between them.
    // ------------------------------------------------------------------
    task automatic send_quad(quad_t q);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 25);
            @(negedge clk);
            vtx.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        @(negedge clk);
        vtx.valid     = 1'b1;
        vtx.vertex0_x = q[0][0]; vtx.vertex0_y = q[0][1]; vtx.vertex0_z = q[0][2];
        vtx.vertex1_x = q[1][0]; vtx.vertex1_y = q[1][1]; vtx.vertex1_z = q[1][2];
        vtx.vertex2_x = q[2][0]; vtx.vertex2_y = q[2][1]; vtx.vertex2_z = q[2][2];
        vtx.vertex3_x = q[3][0]; vtx.vertex3_y = q[3][1]; vtx.vertex3_z = q[3][2];
        do
            @(posedge clk);
        while (!vtx.ready);
        pending_normals.insert(pending_normals.size(), face_normal(q, thr_model));
        burst_left--;
    endtask

    // Drop valid and let every pending normal drain.
    task automatic drain_normals();
        @(negedge clk);
        vtx.valid = 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Threshold is only written with the block idle.
    task automatic set_threshold(logic [THR_BITS-1:0] value);
        drain_normals();
        @(negedge clk);
        wr_en   = 1'b1;
        wr_data = value;
        @(negedge clk);
        wr_en   = 1'b0;
        wr_data = $urandom;
        thr_model = value;
    endtask

    function automatic coord_t rand_coord(int bits);
        logic [CB-1:0] raw;
        raw = CB'($urandom);
        if (bits >= CB)
            return raw;
        return coord_t'($signed(raw[CB-1:0] << (CB - bits)) >>> (CB - bits));
    endfunction

    function automatic quad_t uniform_quad(logic signed [CB-1:0] val);
        quad_t q;
        foreach (q[i, k])
            q[i][k] = val;
        return q;
    endfunction

    // Random quad: half general at random scale, the rest extreme values, all equal, or
    // coincident or collinear vertices so later triples get picked.
    function automatic quad_t random_quad();
        quad_t q;
        int    bits, kind, a, b;
        coord_t ext[4];
        ext = '{coord_t'({1'b1, {(CB-1){1'b0}}}), coord_t'({1'b0, {(CB-1){1'b1}}}),
                coord_t'(0), coord_t'(-1)};
        bits = $urandom_range(0, 3) == 0 ? CB : $urandom_range(1, CB);
        kind = $urandom_range(0, 9);
        foreach (q[i, k])
            q[i][k] = rand_coord(bits);
        case (kind)
            0, 1:
            begin
                // one vertex duplicated onto another
                a = $urandom_range(0, 3);
                b = $urandom_range(0, 3);
                q[b] = q[a];
            end
            2:
            begin
                // vertices 0,2,3 collinear, vertex 1 close to vertex 0
                for (int k = 0; k < 3; k++)
                begin
                    q[0][k] = rand_coord(CB - 3);
                    q[2][k] = q[0][k] + rand_coord(bits > 18 ? 18 : bits);
                    q[3][k] = q[0][k] - (q[2][k] - q[0][k]);
                    q[1][k] = q[0][k] + rand_coord(3);
                end
            end
            3:
                foreach (q[i, k])
                    q[i][k] = ext[$urandom_range(0, 3)];
            4:
                q = uniform_quad(rand_coord(CB));
            default: ;
        endcase
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Edge cases at the reset threshold, then at threshold 2.
    task automatic test_directed();
        quad_t q;
        coord_t mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        // unit right triangle in the xy plane
        q = '{'{0, 0, 0}, '{65536, 0, 0}, '{0, 65536, 0}, '{0, 0, 0}};
        send_quad(q);
        // all vertices equal: everything degenerate
        send_quad(uniform_quad(0));
        send_quad(uniform_quad(mx));
        send_quad(uniform_quad(mn));
        // field extremes, largest possible cross products
        q = '{'{mx, mn, mx}, '{mn, mx, mn}, '{mn, mn, mx}, '{mx, mx, mn}};
        send_quad(q);
        q = '{'{mn, mn, mn}, '{mx, mn, mn}, '{mn, mx, mn}, '{mn, mn, mx}};
        send_quad(q);
        q = '{'{mx, mx, mx}, '{mn, mx, mx}, '{mx, mn, mx}, '{mx, mx, mn}};
        send_quad(q);
        // v0 == v1: triples 0 and 1 vanish, triple 2 picked
        q = '{'{5, 7, 9}, '{5, 7, 9}, '{100, -3, 40}, '{-20, 60, 1}};
        send_quad(q);
        // v0 == v2: triple 1 picked
        q = '{'{5, 7, 9}, '{-100, 3, 40}, '{5, 7, 9}, '{-20, 60, 1}};
        send_quad(q);
        // smallest nonzero cross products, below the reset threshold
        q = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{1, 1, 0}};
        send_quad(q);
        // exactly at the threshold (43) along z
        q = '{'{0, 0, 0}, '{43, 0, 0}, '{0, 1, 0}, '{0, 0, 0}};
        send_quad(q);
        // one below it: degenerate
        q = '{'{0, 0, 0}, '{42, 0, 0}, '{0, 1, 0}, '{0, 0, 0}};
        send_quad(q);
        // only the last triple clears the threshold
        set_threshold(32'd2);
        q = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, -1, 0}};
        send_quad(q);
        // negative components on every axis
        q = '{'{0, 0, 0}, '{-3, 2, -1}, '{1, -4, 5}, '{0, 0, 0}};
        send_quad(q);
        q = '{'{-1, -1, -1}, '{0, 0, 0}, '{-1, -1, -1}, '{0, 0, 0}};
        send_quad(q);
    endtask

    // Threshold zero: only exactly zero cross products are degenerate.
    task automatic test_threshold_zero();
        quad_t q;
        set_threshold('0);
        q = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{1, 1, 0}};
        send_quad(q);
        send_quad(uniform_quad(-7));
        repeat (120)
            send_quad(random_quad());
    endtask

    // Largest threshold: small quads all degenerate, large ones qualify.
    task automatic test_threshold_max();
        set_threshold('1);
        repeat (120)
            send_quad(random_quad());
    endtask

    // Main random load over a spread of thresholds.
    task automatic test_random();
        logic [THR_BITS-1:0] thr;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: thr = THR_RESET;
                1: thr = $urandom;
                2: thr = $urandom_range(0, 255);
                3: thr = 32'd1 << $urandom_range(8, 31);
                default: thr = $urandom >> $urandom_range(0, 31);
            endcase
            set_threshold(thr);
            repeat (250)
                send_quad(random_quad());
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        wr_en       = 1'b0;
        wr_data     = '0;
        fail_cnt    = 0;
        burst_left  = 0;
        idle_cycles = 0;
        thr_model   = THR_RESET;
        vtx.valid   = 1'b0;
        vtx.vertex0_x = '0; vtx.vertex0_y = '0; vtx.vertex0_z = '0;
        vtx.vertex1_x = '0; vtx.vertex1_y = '0; vtx.vertex1_z = '0;
        vtx.vertex2_x = '0; vtx.vertex2_y = '0; vtx.vertex2_z = '0;
        vtx.vertex3_x = '0; vtx.vertex3_y = '0; vtx.vertex3_z = '0;
        nrm.ready   = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_threshold_zero();
        test_threshold_max();
        test_random();

        drain_normals();
        repeat (300) @(posedge clk);
        if (pending_normals.size() != 0)
        begin
            $error("%0d predicted normals never arrived", pending_normals.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("** quad_face_unit_normal: PASSED **");
        else
            $display("** quad_face_unit_normal: FAILED **");
        $finish;
    end

endmodule
